### rtl/hsvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared payload types, sector codes and fixed-point constants.
// ----------------------------------------------------------------------------
package hsvc_pkg;

	localparam logic [6:0] PCT_MAX = 7'd100;

	// Sector span in degrees
	localparam logic [8:0] SECTOR_DEG = 9'd60;

	// Value scaled to full range: v * 6000, chroma: s * v * 60
	localparam logic [19:0] VAL_SCALE    = 20'd6000;
	localparam logic [19:0] CHROMA_SCALE = 20'd60;

	// floor(x*255/600000) = floor(floor(x*17/64) / 625)
	// floor(w/625) = (w * RECIP) >> RECIP_SHIFT for w < 2^18
	localparam logic [18:0] RECIP       = 19'd429497;
	localparam int          RECIP_SHIFT = 28;

	localparam int Q_DEPTH   = 4;
	localparam int Q_AW      = 2;
	localparam int OUT_DEPTH = 8;
	localparam int OUT_AW    = 3;

	typedef enum logic [2:0] {
		SEC_RED_YEL  = 3'd0,
		SEC_YEL_GRN  = 3'd1,
		SEC_GRN_CYN  = 3'd2,
		SEC_CYN_BLU  = 3'd3,
		SEC_BLU_MAG  = 3'd4,
		SEC_MAG_RED  = 3'd5,
		SEC_GREY     = 3'd6
	} sector_t;

	typedef struct packed {
		logic [8:0] hue_deg;
		logic [6:0] sat_pct;
		logic [6:0] val_pct;
	} hsv_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} rgb_out_t;

	// Classified item passed from front to back
	typedef struct packed {
		logic [6:0] sat;
		logic [6:0] val;
		sector_t    sector;
		logic [5:0] factor;
	} front_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

### rtl/hsvc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter front end
// Accepts colors, clamps saturation/value and classifies the hue sector.
// ----------------------------------------------------------------------------
module hsvc_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  hsvc_pkg::hsv_in_t      hsv_in,
	output logic                   q_push,
	output hsvc_pkg::front_item_t  q_item,
	input  hsvc_pkg::q_status_t    q_status
);

	logic                  v_s1;
	hsvc_pkg::front_item_t item_s1;
	hsvc_pkg::front_item_t item_next;
	logic [8:0]            hue;
	logic [8:0]            base;
	logic [8:0]            h_off;
	logic                  take;
	logic                  drain;

	always_comb begin
		hue = hsv_in.hue_deg;
		if (hue < 9'd60) begin
			item_next.sector = hsvc_pkg::SEC_RED_YEL;
			base = 9'd0;
		end else if (hue < 9'd120) begin
			item_next.sector = hsvc_pkg::SEC_YEL_GRN;
			base = 9'd60;
		end else if (hue < 9'd180) begin
			item_next.sector = hsvc_pkg::SEC_GRN_CYN;
			base = 9'd120;
		end else if (hue < 9'd240) begin
			item_next.sector = hsvc_pkg::SEC_CYN_BLU;
			base = 9'd180;
		end else if (hue < 9'd300) begin
			item_next.sector = hsvc_pkg::SEC_BLU_MAG;
			base = 9'd240;
		end else if (hue < 9'd360) begin
			item_next.sector = hsvc_pkg::SEC_MAG_RED;
			base = 9'd300;
		end else begin
			item_next.sector = hsvc_pkg::SEC_GREY;
			base = hue;
		end
		h_off = hue - base;
		// Rising edge within even sectors, falling within odd ones
		if (item_next.sector == hsvc_pkg::SEC_GREY) begin
			item_next.factor = 6'd0;
		end else if (item_next.sector[0]) begin
			item_next.factor = 6'(hsvc_pkg::SECTOR_DEG - h_off);
		end else begin
			item_next.factor = h_off[5:0];
		end
		item_next.sat = (hsv_in.sat_pct > hsvc_pkg::PCT_MAX) ? hsvc_pkg::PCT_MAX
		                                                     : hsv_in.sat_pct;
		item_next.val = (hsv_in.val_pct > hsvc_pkg::PCT_MAX) ? hsvc_pkg::PCT_MAX
		                                                     : hsv_in.val_pct;
	end

	assign drain  = v_s1 && !q_status.full;
	assign full   = v_s1 && q_status.full;
	assign take   = push && !full;
	assign q_push = v_s1;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (drain) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_next;
		end
	end

	// Held item must not change while the queue is full
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && q_status.full) |=> (v_s1 && $stable(item_s1)))
		else $error("front item lost while queue full");

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (item_s1.sat <= hsvc_pkg::PCT_MAX && item_s1.val <= hsvc_pkg::PCT_MAX))
		else $error("unclamped percent in front stage");

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (item_s1.factor <= 6'd60))
		else $error("hue factor out of range");

endmodule

### rtl/hsvc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter decoupling queue
// Small show-ahead FIFO between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module hsvc_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  hsvc_pkg::front_item_t  din,
	input  logic                   pop,
	output hsvc_pkg::front_item_t  dout,
	output hsvc_pkg::q_status_t    status
);

	hsvc_pkg::front_item_t        mem [hsvc_pkg::Q_DEPTH];
	logic [hsvc_pkg::Q_AW-1:0]    wr_ptr_q;
	logic [hsvc_pkg::Q_AW-1:0]    rd_ptr_q;
	logic [hsvc_pkg::Q_AW:0]      cnt_q;
	logic                         wr_en;
	logic                         rd_en;

	assign status.full  = (cnt_q == (hsvc_pkg::Q_AW+1)'(hsvc_pkg::Q_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign wr_en        = push && !status.full;
	assign rd_en        = pop && !status.empty;
	assign dout         = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (hsvc_pkg::Q_AW+1)'(wr_en) - (hsvc_pkg::Q_AW+1)'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= din;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (hsvc_pkg::Q_AW+1)'(hsvc_pkg::Q_DEPTH))
		else $error("queue count overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count did not advance on write");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree when empty");

endmodule

### rtl/hsvc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter back end
// Scaled chroma/offset arithmetic, channel placement and output buffer.
// ----------------------------------------------------------------------------
module hsvc_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hsvc_pkg::front_item_t  q_item,
	input  hsvc_pkg::q_status_t    q_status,
	output logic                   q_pop,
	output logic                   empty,
	input  logic                   pop,
	output hsvc_pkg::rgb_out_t     rgb_out
);

	// Stage 1: products
	logic                      v_b1;
	logic [13:0]               sv_b1;
	logic [19:0]               vscaled_b1;
	logic [5:0]                factor_b1;
	hsvc_pkg::sector_t         sector_b1;

	// Stage 2: chroma, secondary, offset
	logic                      v_b2;
	logic [19:0]               chroma_b2;
	logic [19:0]               second_b2;
	logic [19:0]               offset_b2;
	hsvc_pkg::sector_t         sector_b2;

	// Stage 3: prescaled channels
	logic                      v_b3;
	logic [17:0]               wr_b3;
	logic [17:0]               wg_b3;
	logic [17:0]               wb_b3;

	logic [19:0]               part_r;
	logic [19:0]               part_g;
	logic [19:0]               part_b;
	logic [19:0]               x_r;
	logic [19:0]               x_g;
	logic [19:0]               x_b;
	logic [23:0]               z_r;
	logic [23:0]               z_g;
	logic [23:0]               z_b;
	logic [36:0]               prod_r;
	logic [36:0]               prod_g;
	logic [36:0]               prod_b;
	hsvc_pkg::rgb_out_t        rgb_next;

	// Output buffer
	hsvc_pkg::rgb_out_t            out_mem [hsvc_pkg::OUT_DEPTH];
	logic [hsvc_pkg::OUT_AW-1:0]   out_wr_q;
	logic [hsvc_pkg::OUT_AW-1:0]   out_rd_q;
	logic [hsvc_pkg::OUT_AW:0]     out_cnt_q;
	logic [1:0]                    inflight;
	logic [hsvc_pkg::OUT_AW+1:0]   committed;
	logic                          out_rd;

	// Issue only when the output buffer has room for everything in flight
	assign inflight  = 2'(v_b1) + 2'(v_b2) + 2'(v_b3);
	assign committed = (hsvc_pkg::OUT_AW+2)'(out_cnt_q) + (hsvc_pkg::OUT_AW+2)'(inflight);
	assign q_pop     = !q_status.empty
	                   && (committed < (hsvc_pkg::OUT_AW+2)'(hsvc_pkg::OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
		end else begin
			v_b1 <= q_pop;
			v_b2 <= v_b1;
			v_b3 <= v_b2;
		end
	end

	always_ff @(posedge clk) begin
		sv_b1      <= 14'(q_item.sat) * 14'(q_item.val);
		vscaled_b1 <= 20'(q_item.val) * hsvc_pkg::VAL_SCALE;
		factor_b1  <= q_item.factor;
		sector_b1  <= q_item.sector;
	end

	always_ff @(posedge clk) begin
		chroma_b2 <= 20'(sv_b1) * hsvc_pkg::CHROMA_SCALE;
		second_b2 <= 20'(sv_b1) * 20'(factor_b1);
		offset_b2 <= vscaled_b1 - 20'(sv_b1) * hsvc_pkg::CHROMA_SCALE;
		sector_b2 <= sector_b1;
	end

	always_comb begin
		part_r = '0;
		part_g = '0;
		part_b = '0;
		case (sector_b2)
			hsvc_pkg::SEC_RED_YEL: begin
				part_r = chroma_b2;
				part_g = second_b2;
			end
			hsvc_pkg::SEC_YEL_GRN: begin
				part_r = second_b2;
				part_g = chroma_b2;
			end
			hsvc_pkg::SEC_GRN_CYN: begin
				part_g = chroma_b2;
				part_b = second_b2;
			end
			hsvc_pkg::SEC_CYN_BLU: begin
				part_g = second_b2;
				part_b = chroma_b2;
			end
			hsvc_pkg::SEC_BLU_MAG: begin
				part_r = second_b2;
				part_b = chroma_b2;
			end
			hsvc_pkg::SEC_MAG_RED: begin
				part_r = chroma_b2;
				part_b = second_b2;
			end
			default: begin
			end
		endcase
		x_r = part_r + offset_b2;
		x_g = part_g + offset_b2;
		x_b = part_b + offset_b2;
		// times 17, then drop the power-of-two part of 40000
		z_r = {x_r, 4'd0} + 24'(x_r);
		z_g = {x_g, 4'd0} + 24'(x_g);
		z_b = {x_b, 4'd0} + 24'(x_b);
	end

	always_ff @(posedge clk) begin
		wr_b3 <= z_r[23:6];
		wg_b3 <= z_g[23:6];
		wb_b3 <= z_b[23:6];
	end

	// Divide by 625 through the reciprocal
	always_comb begin
		prod_r = 37'(wr_b3) * 37'(hsvc_pkg::RECIP);
		prod_g = 37'(wg_b3) * 37'(hsvc_pkg::RECIP);
		prod_b = 37'(wb_b3) * 37'(hsvc_pkg::RECIP);
		rgb_next.red_out   = prod_r[hsvc_pkg::RECIP_SHIFT +: 8];
		rgb_next.green_out = prod_g[hsvc_pkg::RECIP_SHIFT +: 8];
		rgb_next.blue_out  = prod_b[hsvc_pkg::RECIP_SHIFT +: 8];
	end

	assign empty   = (out_cnt_q == '0);
	assign out_rd  = pop && !empty;
	assign rgb_out = out_mem[out_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= '0;
			out_rd_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (v_b3) begin
				out_wr_q <= out_wr_q + 1'b1;
			end
			if (out_rd) begin
				out_rd_q <= out_rd_q + 1'b1;
			end
			out_cnt_q <= out_cnt_q + (hsvc_pkg::OUT_AW+1)'(v_b3)
			             - (hsvc_pkg::OUT_AW+1)'(out_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (v_b3) begin
			out_mem[out_wr_q] <= rgb_next;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		committed <= (hsvc_pkg::OUT_AW+2)'(hsvc_pkg::OUT_DEPTH))
		else $error("output buffer overcommitted");

	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> v_b1 ##1 v_b2 ##1 v_b3)
		else $error("issued transaction dropped from pipeline");

	assert property (@(posedge clk) disable iff (!arst_n)
		(empty) |-> (out_wr_q == out_rd_q))
		else $error("output pointers disagree when empty");

endmodule

### rtl/hsv_to_rgb_converter_core.sv
`timescale 1ns / 1ps
// An accepted color passes the front register, the decoupling queue, back-end stages b1,
// b2 and b3 and the output buffer before it can be popped from the result ports.
// Throughput: one color per cycle, sustained.
// The issue gate into the 3-stage arithmetic pipe (8-entry output buffer) sets the limit
// when results are not popped. Reset clears all valid bits and queue pointers; no
// clearing pass, so push is accepted as soon as reset is released.
// ----------------------------------------------------------------------------
// HSV to RGB converter core
// Front end classification, decoupling queue and arithmetic back end.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  hsvc_pkg::hsv_in_t   hsv_in,
	output logic                empty,
	input  logic                pop,
	output hsvc_pkg::rgb_out_t  rgb_out
);

	logic                   q_push;
	logic                   q_pop;
	hsvc_pkg::front_item_t  q_din;
	hsvc_pkg::front_item_t  q_dout;
	hsvc_pkg::q_status_t    q_status;

	hsvc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.hsv_in   (hsv_in),
		.q_push   (q_push),
		.q_item   (q_din),
		.q_status (q_status)
	);

	hsvc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.status (q_status)
	);

	hsvc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_item   (q_dout),
		.q_status (q_status),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.rgb_out  (rgb_out)
	);

endmodule
